FILE: design/gtgs_pkg.sv
// ----------------------------------------------------------------------------
// gtgs_pkg: shared types and constants of the transition-graph sequencer
//   Command and status codes, configuration register layout and the fixed
//   field widths of the request and result ports.
// ----------------------------------------------------------------------------
package gtgs_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_NODES_DEF  = 32;
  localparam int TICK_WIDTH_DEF = 48;

  // Fixed port field widths
  localparam int CMD_W       = 3;
  localparam int NODE_W      = 5;
  localparam int PREV_W      = 6;
  localparam int NCNT_W      = 6;
  localparam int CNT_W       = 7;
  localparam int OUT_TICK_W  = 48;
  localparam int EDGE_CNT_W  = 11;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;

  // Code for "no node" in previous and pending node fields
  localparam logic [PREV_W-1:0] NONE_ID = PREV_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_EDGE = 3'd0,
    CMD_COMPILE  = 3'd1,
    CMD_REQUEST  = 3'd2,
    CMD_ADVANCE  = 3'd3,
    CMD_RESTART  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NOT_COMPILED = 2'd1,
    ST_COMPILED     = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NODES = 1'd0,
    REG_ENTRY = 1'd1
  } cfg_idx_e;

  // Configuration register contents
  typedef struct packed {
    logic [NCNT_W-1:0] num_nodes;
    logic [NODE_W-1:0] entry_node;
  } cfg_t;

endpackage

FILE: design/gtgs_edge_mem.sv
// ----------------------------------------------------------------------------
// gtgs_edge_mem: adjacency matrix storage
//   One row per source node, one bit per destination. Synchronous read through
//   a registered output, one write port. Per-row valid bits cleared by reset
//   make an unwritten row read as zero.
// ----------------------------------------------------------------------------
module gtgs_edge_mem import gtgs_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic [MAX_NODES-1:0]         rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [MAX_NODES-1:0]         wr_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] mem_q;
  logic                 vld_q;

  // Write port: store row data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written rows valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // Read port: register row and its valid bit
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= row_valid[rd_addr];
    end
  end

  // Drop data of rows never written
  assign rd_data = vld_q ? mem_q : '0;

endmodule

FILE: design/gtgs_cfg_regs.sv
// ----------------------------------------------------------------------------
// gtgs_cfg_regs: configuration registers
//   Holds the node count and start node, written through a valid/ready
//   channel that is always ready.
// ----------------------------------------------------------------------------
module gtgs_cfg_regs import gtgs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  // Update the addressed register on each write request
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_nodes  <= NCNT_W'(1);
      cfg.entry_node <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e'(cfg_index))
        REG_NODES: cfg.num_nodes  <= cfg_data;
        REG_ENTRY: cfg.entry_node <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/guarded_transition_graph_sequencer_top.sv
// ----------------------------------------------------------------------------
// guarded_transition_graph_sequencer_top: programmable state sequencer
//   Steps a current node along a table of legal transitions held in an
//   adjacency memory, with tick counters and a range-checked request.
// ----------------------------------------------------------------------------
// Each command is accepted in a cycle that reads one adjacency row (the source
// node of an edge, or the current node of an advance) from the synchronous
// edge memory; the next cycle, with busy high, evaluates the command and, for
// a new edge, writes the row back. The result appears with done for one cycle
// right after that, while the next command may already be accepted; no new
// command is taken while busy is high. The receiver cannot stall:
// results must be captured in the cycle done is high. No clearing pass runs
// after reset; the edge table reads as empty at once. Configuration writes
// are always ready and are meant for times when no command is in flight.
// ----------------------------------------------------------------------------
module guarded_transition_graph_sequencer_top import gtgs_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       cmd,
  input  logic [NODE_W-1:0]      src_node,
  input  logic [NODE_W-1:0]      target_node,
  // result channel
  output logic                   done,
  output logic [NODE_W-1:0]      node_now,
  output logic [PREV_W-1:0]      last_node,
  output logic                   changed,
  output logic [OUT_TICK_W-1:0]  tick_total,
  output logic [OUT_TICK_W-1:0]  node_ticks,
  output logic [EDGE_CNT_W-1:0]  edge_total,
  output logic [STATUS_W-1:0]    status,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ROW_W = $clog2(MAX_NODES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  cfg_t   cfg;

  // sequencer state
  logic                  compiled, compiled_next;
  logic [NODE_W-1:0]     current_id, current_id_next;
  logic [PREV_W-1:0]     previous_id, previous_id_next;
  logic [PREV_W-1:0]     pending_request, pending_request_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [TICK_WIDTH-1:0] enter_tick, enter_tick_next;
  logic                  restart_pending, restart_pending_next;
  logic [EDGE_CNT_W-1:0] edge_counter, edge_counter_next;
  logic [NODE_W-1:0]     max_end, max_end_next;

  // latched request
  cmd_e                  cmd_q;
  logic [NODE_W-1:0]     from_q;
  logic [NODE_W-1:0]     target_q;

  // memory port
  logic                  rd_en;
  logic [ROW_W-1:0]      rd_addr;
  logic [MAX_NODES-1:0]  rd_row;
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_addr;
  logic [MAX_NODES-1:0]  wr_data;

  logic [CNT_W-1:0]      n_used;
  logic                  accept;
  logic                  changed_next;
  status_e               status_next;

  gtgs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gtgs_edge_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  // Clamp node count to the table size
  always_comb begin
    if ({1'b0, cfg.num_nodes} > CNT_W'(MAX_NODES)) begin
      n_used = CNT_W'(MAX_NODES);
    end else begin
      n_used = {1'b0, cfg.num_nodes};
    end
  end

  // Fetch the row of the source node, or of the current node on advance
  assign rd_en   = accept;
  assign rd_addr = (cmd_e'(cmd) == CMD_ADVANCE) ? ROW_W'(current_id) : ROW_W'(src_node);

  // Sequencing: enter the evaluate state after each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (accept) state <= S_EXEC;
        S_EXEC:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the request fields for the evaluate cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd_e'(cmd);
      from_q   <= src_node;
      target_q <= target_node;
    end
  end

  // Evaluate the command against the fetched row
  always_comb begin
    logic [PREV_W-1:0] req_t;
    logic [NODE_W-1:0] larger;

    compiled_next        = compiled;
    current_id_next      = current_id;
    previous_id_next     = previous_id;
    pending_request_next = pending_request;
    tick_count_next      = tick_count;
    enter_tick_next      = enter_tick;
    restart_pending_next = restart_pending;
    edge_counter_next    = edge_counter;
    max_end_next         = max_end;
    changed_next         = 1'b0;
    status_next          = ST_OK;
    wr_en                = 1'b0;
    wr_addr              = ROW_W'(from_q);
    wr_data              = rd_row | (MAX_NODES'(1) << ROW_W'(target_q));
    req_t                = pending_request;
    larger               = (from_q > target_q) ? from_q : target_q;

    case (cmd_q)
      CMD_ADD_EDGE: begin
        if (compiled) begin
          status_next = ST_COMPILED;
        end else if ({2'b0, from_q} >= n_used || {2'b0, target_q} >= n_used) begin
          status_next = ST_RANGE;
        end else if (!rd_row[ROW_W'(target_q)]) begin
          wr_en             = 1'b1;
          edge_counter_next = edge_counter + EDGE_CNT_W'(1);
          if (edge_counter == '0 || larger > max_end) begin
            max_end_next = larger;
          end
        end
      end
      CMD_COMPILE: begin
        if (n_used == '0 || {2'b0, cfg.entry_node} >= n_used
            || (edge_counter != '0 && {2'b0, max_end} >= n_used)) begin
          compiled_next = 1'b0;
          status_next   = ST_RANGE;
        end else begin
          compiled_next        = 1'b1;
          current_id_next      = cfg.entry_node;
          previous_id_next     = NONE_ID;
          pending_request_next = NONE_ID;
          tick_count_next      = '0;
          enter_tick_next      = '0;
          restart_pending_next = 1'b0;
        end
      end
      CMD_REQUEST: begin
        if ({2'b0, target_q} >= n_used) begin
          status_next = ST_RANGE;
        end else begin
          pending_request_next = {1'b0, target_q};
        end
      end
      CMD_ADVANCE: begin
        if (!compiled) begin
          status_next = ST_NOT_COMPILED;
        end else if ({2'b0, current_id} >= n_used) begin
          status_next = ST_RANGE;
        end else begin
          // apply a pending request only along a stored edge
          if (req_t != NONE_ID) begin
            pending_request_next = NONE_ID;
            if ({1'b0, req_t} < n_used && rd_row[ROW_W'(req_t)]) begin
              previous_id_next = {1'b0, current_id};
              current_id_next  = req_t[NODE_W-1:0];
              changed_next     = 1'b1;
            end
          end
          // skip the tick on the first advance after restart
          if (restart_pending) begin
            restart_pending_next = 1'b0;
          end else begin
            tick_count_next = tick_count + TICK_WIDTH'(1);
            if (changed_next) begin
              enter_tick_next = tick_count_next;
            end
          end
        end
      end
      CMD_RESTART: begin
        if (!compiled) begin
          status_next = ST_NOT_COMPILED;
        end else begin
          current_id_next      = cfg.entry_node;
          previous_id_next     = NONE_ID;
          pending_request_next = NONE_ID;
          tick_count_next      = '0;
          enter_tick_next      = '0;
          restart_pending_next = 1'b1;
        end
      end
      default: ;
    endcase

    if (state != S_EXEC) begin
      wr_en = 1'b0;
    end
  end

  // Commit state at the end of the evaluate cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      compiled        <= 1'b0;
      current_id      <= '0;
      previous_id     <= NONE_ID;
      pending_request <= NONE_ID;
      tick_count      <= '0;
      enter_tick      <= '0;
      restart_pending <= 1'b0;
      edge_counter    <= '0;
      max_end         <= '0;
    end else if (state == S_EXEC) begin
      compiled        <= compiled_next;
      current_id      <= current_id_next;
      previous_id     <= previous_id_next;
      pending_request <= pending_request_next;
      tick_count      <= tick_count_next;
      enter_tick      <= enter_tick_next;
      restart_pending <= restart_pending_next;
      edge_counter    <= edge_counter_next;
      max_end         <= max_end_next;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      node_now   <= current_id_next;
      last_node  <= previous_id_next;
      changed    <= changed_next;
      tick_total <= OUT_TICK_W'(tick_count_next);
      node_ticks <= OUT_TICK_W'(tick_count_next - enter_tick_next);
      edge_total <= edge_counter_next;
      status     <= status_next;
    end
  end

  // Every accepted request yields an evaluate state, then one result
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 (done && !busy))
    else $error("accepted request did not produce a result in two cycles");

  // A move reports success and records the node it left
  a_changed_ok: assert property (@(posedge clk) disable iff (rst)
    (done && changed) |-> (status == ST_OK && last_node != NONE_ID))
    else $error("node change reported with bad status or no node left");

  // The edge count only ever grows by one
  a_edge_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && edge_counter != $past(edge_counter))
      |-> edge_counter == EDGE_CNT_W'($past(edge_counter) + EDGE_CNT_W'(1)))
    else $error("edge count changed by other than one");

endmodule

FILE: bench/guarded_transition_graph_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// guarded_transition_graph_sequencer_top_tb: self-checking bench of the sequencer
//   Builds edge tables, compiles them and walks the graph with request and
//   advance commands under random start gaps and changing node ranges. A
//   local model of the sequencer predicts every result, which is then
//   compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module guarded_transition_graph_sequencer_top_tb;
  import gtgs_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } seq_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]     cur;
    logic [PREV_W-1:0]     prev;
    logic                  moved;
    logic [OUT_TICK_W-1:0] tick;
    logic [OUT_TICK_W-1:0] dwell;
    logic [EDGE_CNT_W-1:0] edges;
    logic [STATUS_W-1:0]   st;
  } seq_outcome_t;

  // DUT inputs, known from time zero
  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   start       = 1'b0;
  logic [CMD_W-1:0]       cmd         = CMD_ADD_EDGE;
  logic [NODE_W-1:0]      src_node    = '0;
  logic [NODE_W-1:0]      target_node = '0;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = REG_NODES;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  // DUT outputs
  logic                   busy;
  logic                   done;
  logic [NODE_W-1:0]      node_now;
  logic [PREV_W-1:0]      last_node;
  logic                   changed;
  logic [OUT_TICK_W-1:0]  tick_total;
  logic [OUT_TICK_W-1:0]  node_ticks;
  logic [EDGE_CNT_W-1:0]  edge_total;
  logic [STATUS_W-1:0]    status;
  logic                   cfg_ready;

  // Sequencer model state
  logic [MAX_NODES_DEF-1:0] adj_rows [MAX_NODES_DEF];
  logic                     compiled_q;
  logic [NODE_W-1:0]        cur_id;
  logic [PREV_W-1:0]        prev_id;
  logic [PREV_W-1:0]        req_id;
  logic [OUT_TICK_W-1:0]    tick_q;
  logic [OUT_TICK_W-1:0]    entry_tick;
  logic                     skip_tick;
  logic [EDGE_CNT_W-1:0]    edge_cnt;
  logic [NCNT_W-1:0]        reg_nodes;
  logic [NODE_W-1:0]        reg_start;

  // Bench bookkeeping
  seq_cmd_t     cmd_backlog [$];
  seq_outcome_t awaited_outcomes [$];
  seq_cmd_t     next_cmd;
  logic         cmd_taken = 1'b0;
  int           idle_pct = 19;
  int           queued = 0;
  int           accepted = 0;
  int           rand_items = 0;
  int           checked = 0;
  int           moves = 0;
  int           reg_writes = 0;
  int           mismatch_count = 0;

  guarded_transition_graph_sequencer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .src_node    (src_node),
    .target_node (target_node),
    .done        (done),
    .node_now    (node_now),
    .last_node   (last_node),
    .changed     (changed),
    .tick_total  (tick_total),
    .node_ticks  (node_ticks),
    .edge_total  (edge_total),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Clock and the single reset pulse
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Enter the start node and zero the clocks
  function automatic void enter_start_node();
    cur_id     = reg_start;
    prev_id    = NONE_ID;
    req_id     = NONE_ID;
    tick_q     = '0;
    entry_tick = '0;
  endfunction

  // Apply one command to the model and return the result it shows
  function automatic seq_outcome_t step_outcome(input logic [CMD_W-1:0] op,
                                                input logic [NODE_W-1:0] src,
                                                input logic [NODE_W-1:0] dst);
    seq_outcome_t             o;
    logic [NCNT_W-1:0]        n;
    logic [PREV_W-1:0]        t;
    logic [MAX_NODES_DEF-1:0] in_mask;
    logic                     fits;
    logic                     moved;
    status_e                  st;
    n     = (reg_nodes > MAX_NODES_DEF) ? NCNT_W'(MAX_NODES_DEF) : reg_nodes;
    st    = ST_OK;
    moved = 1'b0;
    case (op)
      CMD_ADD_EDGE: begin
        if (compiled_q) begin
          st = ST_COMPILED;
        end else if (src >= n || dst >= n) begin
          st = ST_RANGE;
        end else if (!adj_rows[src][dst]) begin
          adj_rows[src][dst] = 1'b1;
          edge_cnt++;
        end
      end
      CMD_COMPILE: begin
        // every stored edge must stay inside the node range
        in_mask = (n >= MAX_NODES_DEF) ? '1 : ((MAX_NODES_DEF'(1) << n) - 1'b1);
        fits = 1'b1;
        for (int i = 0; i < MAX_NODES_DEF; i++) begin
          if (i >= n) fits &= (adj_rows[i] == '0);
          else fits &= ((adj_rows[i] & ~in_mask) == '0);
        end
        if (n == 0 || reg_start >= n || !fits) begin
          compiled_q = 1'b0;
          st = ST_RANGE;
        end else begin
          compiled_q = 1'b1;
          enter_start_node();
          skip_tick = 1'b0;
        end
      end
      CMD_REQUEST: begin
        if (dst >= n) st = ST_RANGE;
        else req_id = PREV_W'(dst);
      end
      CMD_ADVANCE: begin
        if (!compiled_q) begin
          st = ST_NOT_COMPILED;
        end else if (cur_id >= n) begin
          st = ST_RANGE;
        end else begin
          // take the pending request only along a stored edge
          if (req_id != NONE_ID) begin
            t = req_id;
            req_id = NONE_ID;
            if (t < n && adj_rows[cur_id][t[NODE_W-1:0]]) begin
              prev_id = PREV_W'(cur_id);
              cur_id  = t[NODE_W-1:0];
              moved   = 1'b1;
            end
          end
          if (skip_tick) begin
            skip_tick = 1'b0;
          end else begin
            tick_q++;
            if (moved) entry_tick = tick_q;
          end
        end
      end
      CMD_RESTART: begin
        if (!compiled_q) begin
          st = ST_NOT_COMPILED;
        end else begin
          enter_start_node();
          skip_tick = 1'b1;
        end
      end
      default: ;
    endcase
    o.cur   = cur_id;
    o.prev  = prev_id;
    o.moved = moved;
    o.tick  = tick_q;
    o.dwell = tick_q - entry_tick;
    o.edges = edge_cnt;
    o.st    = st;
    return o;
  endfunction

  // Drive the next request at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (!rst && (!start || cmd_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_cmd = cmd_backlog.pop_front();
        start       <= 1'b1;
        cmd         <= next_cmd.op;
        src_node    <= next_cmd.src;
        target_node <= next_cmd.dst;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check results, predict accepted requests, track register writes
  always @(posedge clk) begin : monitor
    seq_outcome_t want;
    cmd_taken = 1'b0;
    if (!rst) begin
      if (done === 1'b1) begin
        if (awaited_outcomes.size() == 0) begin
          note_mismatch("result with nothing awaited");
        end else begin
          want = awaited_outcomes.pop_front();
          checked++;
          if (want.moved) moves++;
          if (node_now !== want.cur)
            note_mismatch($sformatf("node_now got %0d want %0d", node_now, want.cur));
          if (last_node !== want.prev)
            note_mismatch($sformatf("last_node got %0d want %0d", last_node, want.prev));
          if (changed !== want.moved)
            note_mismatch($sformatf("changed got %0b want %0b", changed, want.moved));
          if (tick_total !== want.tick)
            note_mismatch($sformatf("tick_total got %0d want %0d", tick_total, want.tick));
          if (node_ticks !== want.dwell)
            note_mismatch($sformatf("node_ticks got %0d want %0d", node_ticks, want.dwell));
          if (edge_total !== want.edges)
            note_mismatch($sformatf("edge_total got %0d want %0d", edge_total, want.edges));
          if (status !== want.st)
            note_mismatch($sformatf("status got %0d want %0d", status, want.st));
        end
      end
      if (start && !busy) begin
        cmd_taken = 1'b1;
        accepted++;
        awaited_outcomes.push_back(step_outcome(cmd, src_node, target_node));
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_NODES: reg_nodes = cfg_data[NCNT_W-1:0];
          REG_ENTRY: reg_start = cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [NODE_W-1:0] src,
                          input logic [NODE_W-1:0] dst);
    cmd_backlog.push_back('{op: op, src: src, dst: dst});
    queued++;
    if (op <= CMD_RESTART) rand_items++;
  endtask

  // Wait until every request is taken and every result is back
  task automatic drain();
    while (accepted != queued || awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random commands, mostly request/advance pairs aimed at the busy nodes
  task automatic random_walk(input int n, input int count);
    int               r;
    int               hot;
    logic [NODE_W-1:0] tgt;
    hot = (n < 6) ? n : 6;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if ($urandom_range(99) < 5) tgt = NODE_W'($urandom);
      else if ($urandom_range(99) < 70) tgt = NODE_W'($urandom_range(hot - 1));
      else tgt = NODE_W'($urandom_range(n - 1));
      if (r < 55) begin
        push_cmd(CMD_REQUEST, NODE_W'($urandom), tgt);
        push_cmd(CMD_ADVANCE, NODE_W'($urandom), NODE_W'($urandom));
      end else if (r < 65) begin
        push_cmd(CMD_ADVANCE, NODE_W'($urandom), tgt);
      end else if (r < 72) begin
        push_cmd(CMD_REQUEST, NODE_W'($urandom), tgt);
      end else if (r < 78) begin
        push_cmd(CMD_RESTART, NODE_W'($urandom), tgt);
      end else if (r < 82) begin
        push_cmd(CMD_COMPILE, NODE_W'($urandom), tgt);
      end else if (r < 88) begin
        push_cmd(CMD_ADD_EDGE, NODE_W'($urandom), NODE_W'($urandom));
      end else if (r < 93) begin
        push_cmd(CMD_W'($urandom_range(int'(CMD_RESTART) + 1, (1 << CMD_W) - 1)),
                 NODE_W'($urandom), NODE_W'($urandom));
      end else begin
        push_cmd(CMD_RESTART, NODE_W'($urandom), tgt);
        push_cmd(CMD_REQUEST, NODE_W'($urandom), tgt);
        push_cmd(CMD_ADVANCE, NODE_W'($urandom), tgt);
      end
    end
  endtask

  // Stimulus: directed opening, then graph-building episodes
  initial begin
    int                    ep;
    int                    n;
    int                    hot;
    int                    s;
    int                    top_node;
    int                    k;
    logic [NODE_W-1:0]     a;
    logic [NODE_W-1:0]     b;
    logic [CFG_DATA_W-1:0] nreg;

    // model state after reset
    foreach (adj_rows[i]) adj_rows[i] = '0;
    compiled_q = 1'b0;
    reg_nodes  = NCNT_W'(1);
    reg_start  = '0;
    enter_start_node();
    skip_tick  = 1'b0;
    edge_cnt   = '0;

    while (rst) @(posedge clk);

    // directed: four-node graph, every command and the corner cases
    set_reg(REG_NODES, 4);
    set_reg(REG_ENTRY, 0);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_RESTART, 0, 0);
    push_cmd(CMD_REQUEST, 0, 2);
    push_cmd(CMD_ADD_EDGE, 0, 1);
    push_cmd(CMD_ADD_EDGE, 0, 1);
    push_cmd(CMD_ADD_EDGE, 1, 3);
    push_cmd(CMD_ADD_EDGE, 3, 0);
    push_cmd(CMD_ADD_EDGE, 5, 1);
    push_cmd(CMD_ADD_EDGE, 31, 31);
    push_cmd(CMD_COMPILE, 0, 0);
    push_cmd(CMD_ADD_EDGE, 2, 2);
    push_cmd(CMD_REQUEST, 0, 1);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_REQUEST, 0, 31);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_REQUEST, 0, 3);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_REQUEST, 0, 2);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_RESTART, 0, 0);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_REQUEST, 0, 1);
    push_cmd(CMD_ADVANCE, 0, 0);
    push_cmd(CMD_COMPILE, 0, 0);
    push_cmd(CMD_W'(int'(CMD_RESTART) + 1), 31, 31);
    push_cmd(CMD_W'((1 << CMD_W) - 1), 0, 31);
    drain();

    rand_items = 0;
    ep = 0;
    while (rand_items < 1300) begin
      if (rand_items < 433) idle_pct = 19;
      else if (rand_items < 866) idle_pct = 86;
      else idle_pct = 0;

      // highest node touched by a stored edge
      top_node = 0;
      for (int i = 0; i < MAX_NODES_DEF; i++)
        for (int j = 0; j < MAX_NODES_DEF; j++)
          if (adj_rows[i][j] && (i > top_node || j > top_node))
            top_node = (i > j) ? i : j;

      // drop back to uncompiled with an empty node range
      set_reg(REG_NODES, 0);
      push_cmd(CMD_COMPILE, NODE_W'($urandom), NODE_W'($urandom));
      push_cmd(CMD_ADVANCE, NODE_W'($urandom), NODE_W'($urandom));
      push_cmd(CMD_ADD_EDGE, NODE_W'($urandom), NODE_W'($urandom));
      push_cmd(CMD_RESTART, NODE_W'($urandom), NODE_W'($urandom));
      drain();

      // a range below the stored edges must refuse to compile
      if (top_node > 0 && $urandom_range(2) == 0) begin
        set_reg(REG_NODES, CFG_DATA_W'($urandom_range(1, top_node)));
        push_cmd(CMD_COMPILE, NODE_W'($urandom), NODE_W'($urandom));
        push_cmd(CMD_ADVANCE, NODE_W'($urandom), NODE_W'($urandom));
        drain();
      end

      // grow the node range episode by episode
      n = (ep < 8) ? 2 + 4 * ep : MAX_NODES_DEF;
      if (n <= top_node) n = top_node + 1;
      nreg = (n == MAX_NODES_DEF && ep % 2 == 1) ? CFG_DATA_W'((1 << NCNT_W) - 1)
                                                 : CFG_DATA_W'(n);
      hot = (n < 6) ? n : 6;
      s = (ep % 4 == 3) ? n - 1 : $urandom_range(hot - 1);
      set_reg(REG_NODES, nreg);
      set_reg(REG_ENTRY, CFG_DATA_W'(s) | CFG_DATA_W'($urandom_range(1) << NODE_W));

      // edges, mostly among the first few nodes, with exits from the start
      k = n * n / 2 + 2;
      if (k > 40) k = 40;
      for (int i = 0; i < k; i++) begin
        a = ($urandom_range(99) < 80) ? NODE_W'($urandom_range(hot - 1))
                                      : NODE_W'($urandom_range(n - 1));
        b = ($urandom_range(99) < 80) ? NODE_W'($urandom_range(hot - 1))
                                      : NODE_W'($urandom_range(n - 1));
        push_cmd(CMD_ADD_EDGE, a, b);
      end
      push_cmd(CMD_ADD_EDGE, NODE_W'(s), NODE_W'($urandom_range(hot - 1)));
      push_cmd(CMD_ADD_EDGE, NODE_W'($urandom_range(hot - 1)), NODE_W'(s));
      if (n < MAX_NODES_DEF)
        push_cmd(CMD_ADD_EDGE, NODE_W'($urandom_range(n, MAX_NODES_DEF - 1)),
                 NODE_W'($urandom_range(n - 1)));
      push_cmd(CMD_COMPILE, NODE_W'($urandom), NODE_W'($urandom));
      random_walk(n, 60);
      drain();

      // shrink the range under a running sequencer
      if (ep % 3 == 2) begin
        set_reg(REG_NODES, 1);
        set_reg(REG_ENTRY, CFG_DATA_W'(MAX_NODES_DEF - 1));
        random_walk(1, 10);
        drain();
      end
      ep++;
    end

    drain();
    repeat (5) @(posedge clk);
    $display("checked %0d results (%0d node moves) over %0d graph episodes",
             checked, moves, ep);
    $display("%0d register writes, node ranges from empty to full", reg_writes);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
